// ===== hw/rtl/clt_pkg.sv =====
`timescale 1ns / 1ps

package clt_pkg;

	localparam int CONN_SLOTS   = 256;
	localparam int NODE_ENTRIES = 16;
	localparam int NODE_WORDS   = 14;
	localparam int READ_WORDS   = NODE_WORDS + 1;
	localparam int NS_PER_US    = 1000;

	localparam int CONN_AW = $clog2(CONN_SLOTS);
	localparam int NODE_AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
	localparam int ST_DEPTH = NODE_ENTRIES * NODE_WORDS;
	localparam int ST_AW   = $clog2(ST_DEPTH);

	// divide by NS_PER_US: 16-bit digits, each through one reciprocal multiply
	localparam int DIV_DIGIT_W = 16;
	localparam int DIV_STEPS   = 64 / DIV_DIGIT_W;
	localparam int DIV_CW      = $clog2(DIV_STEPS);
	localparam int REM_W       = $clog2(NS_PER_US);
	localparam int DIV_PART_W  = REM_W + DIV_DIGIT_W;
	localparam int DIV_SHIFT   = DIV_PART_W + REM_W;
	localparam int DIV_MAGIC_W = DIV_SHIFT - REM_W + 1;
	localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = DIV_MAGIC_W'(
		((64'd1 << DIV_SHIFT) + 64'(NS_PER_US) - 64'd1) / 64'(NS_PER_US));

	typedef enum logic [1:0] {
		CMD_SEND  = 2'd0,
		CMD_RECV  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	localparam logic [3:0] ST_IN    = 4'd0;
	localparam logic [3:0] ST_OUT   = 4'd1;
	localparam logic [3:0] ST_PID   = 4'd2;
	localparam logic [3:0] ST_REQ   = 4'd3;
	localparam logic [3:0] ST_CHZ   = 4'd4;
	localparam logic [3:0] ST_CUS   = 4'd5;
	localparam logic [3:0] ST_CMAX  = 4'd6;
	localparam logic [3:0] ST_SHZ   = 4'd7;
	localparam logic [3:0] ST_SUS   = 4'd8;
	localparam logic [3:0] ST_SMAX  = 4'd9;
	localparam logic [3:0] ST_CADDR = 4'd10;
	localparam logic [3:0] ST_SADDR = 4'd11;
	localparam logic [3:0] ST_SPORT = 4'd12;
	localparam logic [3:0] ST_DPORT = 4'd13;
	localparam logic [3:0] ST_LAST  = 4'd13;
	localparam logic [3:0] RD_LAST  = 4'd14;

	typedef struct packed {
		logic        is_server;
		logic [31:0] owner;
		logic [31:0] laddr;
		logic [31:0] raddr;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [63:0] bytes_in;
		logic [63:0] bytes_out;
		logic [63:0] eg_first;
		logic [63:0] eg_last;
		logic [63:0] in_first;
		logic [63:0] in_last;
	} conn_rec_t;

	localparam int REC_W = $bits(conn_rec_t);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/clt_ram.sv =====
`timescale 1ns / 1ps

module clt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/clt_div.sv =====
`timescale 1ns / 1ps

module clt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       dividend,
	output clt_pkg::div_stat_t stat,
	output logic [31:0]       quotient
);
	import clt_pkg::*;

	localparam int PROD_W = DIV_PART_W + DIV_MAGIC_W;

	logic [63:0]            dvd_q;
	logic [REM_W-1:0]       rem_q;
	logic [DIV_CW-1:0]      cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIV_PART_W-1:0]  part;
	logic [PROD_W-1:0]      prod;
	logic [DIV_DIGIT_W-1:0] digit;
	logic [DIV_PART_W-1:0]  back;
	logic [DIV_PART_W-1:0]  rem_nx;

	// remainder and next dividend digit, quotient digit by reciprocal multiply
	assign part   = {rem_q, dvd_q[63 -: DIV_DIGIT_W]};
	assign prod   = PROD_W'(part) * PROD_W'(DIV_MAGIC);
	assign digit  = prod[DIV_SHIFT +: DIV_DIGIT_W];
	assign back   = DIV_PART_W'(digit) * DIV_PART_W'(NS_PER_US);
	assign rem_nx = part - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q    <= dividend;
			rem_q    <= '0;
			quotient <= '0;
		end else if (busy_q) begin
			dvd_q    <= {dvd_q[63-DIV_DIGIT_W:0], DIV_DIGIT_W'(0)};
			rem_q    <= rem_nx[REM_W-1:0];
			quotient <= {quotient[31-DIV_DIGIT_W:0], digit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/connection_latency_tracker_unit.sv =====
`timescale 1ns / 1ps

// Connection latency tracker. One beat in, then the block is busy until its
// results are taken. Send, receive and close give one result beat; when an
// exchange closes, the beat waits for the divide by 1000 (four 16-bit digit
// steps through one reciprocal multiply), the node key scan (one entry a
// cycle, up to 16 entries) and the stats read-modify-write pass over the node
// RAM. A node read gives fifteen beats: the node key, then the stats words
// through registered stats RAM reads. No clearing pass after reset.
module connection_latency_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  conn_slot,
	input  logic [63:0] timestamp_ns,
	input  logic [31:0] byte_count,
	input  logic [31:0] local_addr,
	input  logic [31:0] remote_addr,
	input  logic [15:0] local_port,
	input  logic [15:0] remote_port,
	input  logic        listening,
	input  logic [31:0] proc_id,
	input  logic        proc_tracked,
	input  logic [3:0]  node_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        exchange_done,
	output logic        done_role,
	output logic [31:0] response_us,
	output logic [31:0] edge_client,
	output logic [31:0] edge_server,
	output logic        node_dropped,
	output logic [63:0] read_word,
	output logic [3:0]  word_number,
	output logic        last_word
);
	import clt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CRD   = 11'b00000000010,
		S_CEVAL = 11'b00000000100,
		S_DIV   = 11'b00000001000,
		S_NSRCH = 11'b00000010000,
		S_STAT  = 11'b00000100000,
		S_CUPD  = 11'b00001000000,
		S_OUT   = 11'b00010000000,
		S_RREQ  = 11'b00100000000,
		S_RCAP  = 11'b01000000000,
		S_ROUT  = 11'b10000000000
	} state_t;

	state_t state_q;

	cmd_t              cmd_q;
	logic [CONN_AW-1:0] slot_q;
	logic [63:0]       ts_q;
	logic [31:0]       bytes_q;
	logic [31:0]       la_q, ra_q, pid_q;
	logic [15:0]       lp_q, rp_q;
	logic              lis_q, trk_q, rok_q;

	logic [CONN_SLOTS-1:0]   conn_valid_q;
	logic [NODE_ENTRIES-1:0] node_valid_q;
	logic [31:0]             key_q [NODE_ENTRIES];

	conn_rec_t rec_q, rec_new, rec_upd, rec_rd;
	logic [REC_W-1:0] conn_rdata;

	logic [NODE_AW-1:0] sidx_q, n_q, free_q;
	logic               free_found_q, fresh_q, upd_q, iss_q, wv_s1;
	logic [3:0]         w_q, w_s1;
	logic [31:0]        rt_q;

	div_stat_t   div_stat;
	logic        div_start;
	logic [63:0] div_dvd;
	logic [31:0] div_q;

	logic             st_we, st_re;
	logic [ST_AW-1:0] st_waddr, st_raddr, st_base;
	logic [63:0]      st_wdata, st_rdata, old_v, addend, sum_v, rt64;
	logic             gt;

	logic cv, add_ok, srv, fin, hit, freef;
	logic [NODE_AW-1:0] freeidx;
	logic [3:0] rd_w;

	logic        o_done_q, o_role_q, o_drop_q, o_last_q;
	logic [31:0] o_rt_q, o_ec_q, o_es_q;
	logic [63:0] o_word_q;
	logic [3:0]  o_wn_q;

	function automatic logic [63:0] srv_q_ext(input logic want_server);
		srv_q_ext = (rec_q.is_server == want_server) ? 64'd1 : 64'd0;
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_ROUT);

	assign exchange_done = o_done_q;
	assign done_role     = o_role_q;
	assign response_us   = o_rt_q;
	assign edge_client   = o_ec_q;
	assign edge_server   = o_es_q;
	assign node_dropped  = o_drop_q;
	assign read_word     = o_word_q;
	assign word_number   = o_wn_q;
	assign last_word     = o_last_q;

	// connection record evaluation
	assign rec_rd = conn_rec_t'(conn_rdata);
	assign cv     = conn_valid_q[slot_q];
	assign add_ok = (cmd_q != CMD_CLOSE) && trk_q && (la_q != ra_q);

	always_comb begin
		rec_new           = rec_rd;
		if (!cv) begin
			rec_new.is_server = lis_q;
			rec_new.owner     = pid_q;
			rec_new.laddr     = la_q;
			rec_new.raddr     = ra_q;
			rec_new.lport     = lp_q;
			rec_new.rport     = rp_q;
			rec_new.bytes_in  = '0;
			rec_new.bytes_out = '0;
			rec_new.eg_first  = '0;
			rec_new.eg_last   = '0;
			rec_new.in_first  = '0;
			rec_new.in_last   = '0;
		end
	end

	assign srv = rec_new.is_server;
	assign fin = ((cmd_q == CMD_SEND && !srv) || (cmd_q == CMD_RECV && srv) ||
		(cmd_q == CMD_CLOSE)) && (rec_new.eg_first != '0) && (rec_new.in_first != '0);
	assign div_dvd   = srv ? (rec_new.eg_last - rec_new.in_first)
		: (rec_new.in_last - rec_new.eg_first);
	assign div_start = (state_q == S_CEVAL) && (cv || add_ok) && fin;

	always_comb begin
		rec_upd = rec_q;
		case (cmd_q)
			CMD_SEND: begin
				rec_upd.bytes_out = rec_q.bytes_out + 64'(bytes_q);
				if (rec_q.eg_first == '0) begin
					rec_upd.eg_first = ts_q;
				end
				rec_upd.eg_last = ts_q;
			end
			CMD_RECV: begin
				rec_upd.bytes_in = rec_q.bytes_in + 64'(bytes_q);
				if (rec_q.in_first == '0) begin
					rec_upd.in_first = ts_q;
				end
				rec_upd.in_last = ts_q;
			end
			default: begin
			end
		endcase
	end

	clt_ram #(.WIDTH(REC_W), .DEPTH(CONN_SLOTS)) u_conn_ram (
		.clk   (clk),
		.we    ((state_q == S_CUPD) && (cmd_q != CMD_CLOSE)),
		.waddr (slot_q),
		.wdata (rec_upd),
		.re    (state_q == S_CRD),
		.raddr (slot_q),
		.rdata (conn_rdata)
	);

	clt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// node key scan
	assign hit     = node_valid_q[sidx_q] && (key_q[sidx_q] == rec_q.laddr);
	assign freef   = free_found_q || !node_valid_q[sidx_q];
	assign freeidx = free_found_q ? free_q : sidx_q;

	// node stats pass
	assign st_base = ST_AW'(ST_AW'(n_q) * ST_AW'(NODE_WORDS));
	assign rd_w    = (w_q == 4'd0) ? 4'd0 : w_q - 4'd1;
	assign st_re   = ((state_q == S_STAT) && iss_q) || (state_q == S_RREQ);
	assign st_raddr = ST_AW'(st_base + ST_AW'((state_q == S_STAT) ? w_q : rd_w));
	assign st_waddr = ST_AW'(st_base + ST_AW'(w_s1));
	assign st_we    = (state_q == S_STAT) && wv_s1;
	assign old_v    = fresh_q ? '0 : st_rdata;
	assign rt64     = 64'(rt_q);
	assign gt       = rt64 > old_v;

	always_comb begin
		case (w_s1)
			ST_IN:   addend = rec_q.bytes_in;
			ST_OUT:  addend = rec_q.bytes_out;
			ST_REQ:  addend = 64'd1;
			ST_CHZ:  addend = srv_q_ext(1'b0);
			ST_CUS:  addend = rec_q.is_server ? 64'd0 : rt64;
			ST_SHZ:  addend = srv_q_ext(1'b1);
			ST_SUS:  addend = rec_q.is_server ? rt64 : 64'd0;
			default: addend = 64'd0;
		endcase
	end

	assign sum_v = old_v + addend;

	always_comb begin
		case (w_s1)
			ST_PID:   st_wdata = 64'(rec_q.owner);
			ST_CMAX:  st_wdata = (!rec_q.is_server && gt) ? rt64 : old_v;
			ST_SMAX:  st_wdata = (rec_q.is_server && gt) ? rt64 : old_v;
			ST_CADDR: st_wdata = upd_q ? 64'(rec_q.is_server ? rec_q.raddr : rec_q.laddr)
				: old_v;
			ST_SADDR: st_wdata = upd_q ? 64'(rec_q.is_server ? rec_q.laddr : rec_q.raddr)
				: old_v;
			ST_SPORT: st_wdata = upd_q ? 64'(rec_q.is_server ? rec_q.rport : rec_q.lport)
				: old_v;
			ST_DPORT: st_wdata = upd_q ? 64'(rec_q.is_server ? rec_q.lport : rec_q.rport)
				: old_v;
			default:  st_wdata = sum_v;
		endcase
	end

	clt_ram #(.WIDTH(64), .DEPTH(ST_DEPTH)) u_stat_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			conn_valid_q <= '0;
			node_valid_q <= '0;
			iss_q        <= 1'b0;
			wv_s1        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd_t'(command) == CMD_READ) begin
							state_q <= S_RREQ;
						end else if (32'(conn_slot) >= CONN_SLOTS) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_CRD;
						end
					end
				end
				S_CRD: state_q <= S_CEVAL;
				S_CEVAL: begin
					if (!(cv || add_ok)) begin
						state_q <= S_OUT;
					end else if (fin) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_CUPD;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_NSRCH;
					end
				end
				S_NSRCH: begin
					if (hit) begin
						state_q <= S_STAT;
						iss_q   <= 1'b1;
					end else if (32'(sidx_q) == NODE_ENTRIES - 1) begin
						if (freef) begin
							node_valid_q[freeidx] <= 1'b1;
							state_q <= S_STAT;
							iss_q   <= 1'b1;
						end else begin
							state_q <= S_CUPD;
						end
					end
				end
				S_STAT: begin
					wv_s1 <= iss_q;
					if (iss_q && w_q == ST_LAST) begin
						iss_q <= 1'b0;
					end
					if (wv_s1 && w_s1 == ST_LAST) begin
						state_q <= S_CUPD;
					end
				end
				S_CUPD: begin
					conn_valid_q[slot_q] <= (cmd_q != CMD_CLOSE);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_RREQ: state_q <= S_RCAP;
				S_RCAP: state_q <= S_ROUT;
				S_ROUT: begin
					if (out_ready) begin
						state_q <= o_last_q ? S_IDLE : S_RREQ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q   <= cmd_t'(command);
					slot_q  <= CONN_AW'(conn_slot);
					ts_q    <= timestamp_ns;
					bytes_q <= byte_count;
					la_q    <= local_addr;
					ra_q    <= remote_addr;
					lp_q    <= local_port;
					rp_q    <= remote_port;
					lis_q   <= listening;
					pid_q   <= proc_id;
					trk_q   <= proc_tracked;
					sidx_q  <= NODE_AW'(node_index);
					n_q     <= NODE_AW'(node_index);
					rok_q   <= (32'(node_index) < NODE_ENTRIES) &&
						node_valid_q[NODE_AW'(node_index)];
					w_q     <= '0;
					fresh_q <= 1'b0;
					o_done_q <= 1'b0;
					o_role_q <= 1'b0;
					o_rt_q   <= '0;
					o_ec_q   <= '0;
					o_es_q   <= '0;
					o_drop_q <= 1'b0;
					o_word_q <= '0;
					o_wn_q   <= '0;
					o_last_q <= 1'b1;
				end
			end
			S_CEVAL: begin
				rec_q <= rec_new;
				if (fin) begin
					o_done_q <= 1'b1;
					o_role_q <= srv;
					o_ec_q   <= srv ? rec_new.raddr : rec_new.laddr;
					o_es_q   <= srv ? rec_new.laddr : rec_new.raddr;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					rt_q           <= div_q;
					o_rt_q         <= div_q;
					rec_q.eg_first <= '0;
					rec_q.in_first <= '0;
					sidx_q         <= '0;
					free_found_q   <= 1'b0;
				end
			end
			S_NSRCH: begin
				upd_q <= 1'b0;
				w_q   <= '0;
				if (hit) begin
					n_q     <= sidx_q;
					fresh_q <= 1'b0;
				end else if (32'(sidx_q) == NODE_ENTRIES - 1) begin
					if (freef) begin
						n_q     <= freeidx;
						fresh_q <= 1'b1;
						key_q[freeidx] <= rec_q.laddr;
					end else begin
						o_drop_q <= 1'b1;
					end
				end else begin
					if (!node_valid_q[sidx_q] && !free_found_q) begin
						free_q       <= sidx_q;
						free_found_q <= 1'b1;
					end
					sidx_q <= sidx_q + 1'b1;
				end
			end
			S_STAT: begin
				if (iss_q) begin
					w_q <= w_q + 4'd1;
				end
				w_s1 <= w_q;
				if (wv_s1 && ((w_s1 == ST_CMAX && !rec_q.is_server) ||
					(w_s1 == ST_SMAX && rec_q.is_server))) begin
					upd_q <= gt;
				end
				if (wv_s1 && w_s1 == ST_LAST) begin
					rec_q.bytes_in  <= '0;
					rec_q.bytes_out <= '0;
				end
			end
			S_RCAP: begin
				o_word_q <= rok_q ? ((w_q == 4'd0) ? 64'(key_q[sidx_q]) : st_rdata) : '0;
				o_wn_q   <= w_q;
				o_last_q <= (w_q == RD_LAST);
			end
			S_ROUT: begin
				if (out_ready) begin
					w_q <= w_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input taken while a result is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIV))
		else $error("divider running outside divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(node_valid_q) >= $countones($past(node_valid_q)))
		else $error("node entry lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (st_waddr != st_raddr || !st_re))
		else $error("stats read and write collide");

endmodule

// ===== verif/connection_latency_tracker_unit_tb.sv =====
`timescale 1ns / 1ps

module connection_latency_tracker_unit_tb;
	import clt_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_ITEMS = 300;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  slot;
		logic [63:0] ts;
		logic [31:0] bytes;
		logic [31:0] laddr;
		logic [31:0] raddr;
		logic [15:0] lport;
		logic [15:0] rport;
		logic        listen;
		logic [31:0] pid;
		logic        tracked;
		logic [3:0]  nidx;
	} event_t;

	typedef struct packed {
		logic        done;
		logic        role;
		logic [31:0] rt_us;
		logic [31:0] eclient;
		logic [31:0] eserver;
		logic        dropped;
		logic [63:0] word;
		logic [3:0]  wnum;
		logic        last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [7:0]  conn_slot = '0;
	logic [63:0] timestamp_ns = '0;
	logic [31:0] byte_count = '0;
	logic [31:0] local_addr = '0;
	logic [31:0] remote_addr = '0;
	logic [15:0] local_port = '0;
	logic [15:0] remote_port = '0;
	logic        listening = 1'b0;
	logic [31:0] proc_id = '0;
	logic        proc_tracked = 1'b0;
	logic [3:0]  node_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        exchange_done;
	logic        done_role;
	logic [31:0] response_us;
	logic [31:0] edge_client;
	logic [31:0] edge_server;
	logic        node_dropped;
	logic [63:0] read_word;
	logic [3:0]  word_number;
	logic        last_word;

	connection_latency_tracker_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// tracker shadow state
	logic        sl_live [CONN_SLOTS];
	logic        sl_srv [CONN_SLOTS];
	logic [31:0] sl_pid [CONN_SLOTS];
	logic [31:0] sl_la [CONN_SLOTS];
	logic [31:0] sl_ra [CONN_SLOTS];
	logic [15:0] sl_lp [CONN_SLOTS];
	logic [15:0] sl_rp [CONN_SLOTS];
	logic [63:0] sl_bin [CONN_SLOTS];
	logic [63:0] sl_bout [CONN_SLOTS];
	logic [63:0] sl_egf [CONN_SLOTS];
	logic [63:0] sl_egl [CONN_SLOTS];
	logic [63:0] sl_inf [CONN_SLOTS];
	logic [63:0] sl_inl [CONN_SLOTS];
	logic        nd_live [NODE_ENTRIES];
	logic [31:0] nd_addr [NODE_ENTRIES];
	logic [63:0] nd_st [NODE_ENTRIES][NODE_WORDS];

	beat_t expected_beats [$];
	int    mismatches = 0;
	int    items_sent = 0;
	int    burst_left = 0;
	int    idle_cycles = 0;
	logic [63:0] now_ns = 64'd1000;

	function automatic int node_lookup(logic [31:0] addr);
		for (int i = 0; i < NODE_ENTRIES; i++)
			if (nd_live[i] && nd_addr[i] == addr)
				return i;
		for (int i = 0; i < NODE_ENTRIES; i++) begin
			if (!nd_live[i]) begin
				nd_live[i] = 1'b1;
				nd_addr[i] = addr;
				for (int w = 0; w < NODE_WORDS; w++)
					nd_st[i][w] = '0;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void close_exchange(int s, logic srv, ref beat_t r);
		logic [63:0] diff;
		logic [31:0] rt;
		int n;
		if (sl_egf[s] == 0 || sl_inf[s] == 0)
			return;
		diff = srv ? sl_egl[s] - sl_inf[s] : sl_inl[s] - sl_egf[s];
		rt = 32'(diff / 64'd1000);
		sl_egf[s] = '0;
		sl_inf[s] = '0;
		r.done = 1'b1;
		r.role = srv;
		r.rt_us = rt;
		r.eclient = srv ? sl_ra[s] : sl_la[s];
		r.eserver = srv ? sl_la[s] : sl_ra[s];
		n = node_lookup(sl_la[s]);
		if (n < 0) begin
			r.dropped = 1'b1;
			return;
		end
		nd_st[n][ST_IN] += sl_bin[s];
		nd_st[n][ST_OUT] += sl_bout[s];
		sl_bin[s] = '0;
		sl_bout[s] = '0;
		nd_st[n][ST_PID] = 64'(sl_pid[s]);
		nd_st[n][ST_REQ] += 1;
		if (!srv) begin
			nd_st[n][ST_CHZ] += 1;
			nd_st[n][ST_CUS] += 64'(rt);
			if (64'(rt) > nd_st[n][ST_CMAX]) begin
				nd_st[n][ST_CADDR] = 64'(sl_la[s]);
				nd_st[n][ST_SADDR] = 64'(sl_ra[s]);
				nd_st[n][ST_SPORT] = 64'(sl_lp[s]);
				nd_st[n][ST_DPORT] = 64'(sl_rp[s]);
				nd_st[n][ST_CMAX] = 64'(rt);
			end
		end else begin
			nd_st[n][ST_SHZ] += 1;
			nd_st[n][ST_SUS] += 64'(rt);
			if (64'(rt) > nd_st[n][ST_SMAX]) begin
				nd_st[n][ST_SADDR] = 64'(sl_la[s]);
				nd_st[n][ST_CADDR] = 64'(sl_ra[s]);
				nd_st[n][ST_SPORT] = 64'(sl_rp[s]);
				nd_st[n][ST_DPORT] = 64'(sl_lp[s]);
				nd_st[n][ST_SMAX] = 64'(rt);
			end
		end
	endfunction

	function automatic void track_event(event_t e);
		beat_t r;
		int s;
		logic srv;
		r = '0;
		if (e.cmd == CMD_READ) begin
			for (int w = 0; w < READ_WORDS; w++) begin
				r = '0;
				if (nd_live[e.nidx])
					r.word = (w == 0) ? 64'(nd_addr[e.nidx]) : nd_st[e.nidx][w - 1];
				r.wnum = 4'(w);
				r.last = (w == READ_WORDS - 1);
				expected_beats.push_back(r);
			end
			return;
		end
		r.last = 1'b1;
		s = e.slot;
		if (!sl_live[s]) begin
			if (e.cmd == CMD_CLOSE || !e.tracked || e.laddr == e.raddr) begin
				expected_beats.push_back(r);
				return;
			end
			sl_live[s] = 1'b1;
			sl_pid[s] = e.pid;
			sl_la[s] = e.laddr;
			sl_ra[s] = e.raddr;
			sl_lp[s] = e.lport;
			sl_rp[s] = e.rport;
			sl_srv[s] = e.listen;
			sl_bin[s] = '0;
			sl_bout[s] = '0;
			sl_egf[s] = '0;
			sl_egl[s] = '0;
			sl_inf[s] = '0;
			sl_inl[s] = '0;
		end
		srv = sl_srv[s];
		case (e.cmd)
			CMD_SEND: begin
				if (!srv)
					close_exchange(s, 1'b0, r);
				sl_bout[s] += 64'(e.bytes);
				if (sl_egf[s] == 0)
					sl_egf[s] = e.ts;
				sl_egl[s] = e.ts;
			end
			CMD_RECV: begin
				if (srv)
					close_exchange(s, 1'b1, r);
				sl_bin[s] += 64'(e.bytes);
				if (sl_inf[s] == 0)
					sl_inf[s] = e.ts;
				sl_inl[s] = e.ts;
			end
			default: begin
				close_exchange(s, srv, r);
				sl_live[s] = 1'b0;
			end
		endcase
		expected_beats.push_back(r);
	endfunction

	task automatic send_event(event_t e);
		if (burst_left == 0)
			burst_left = $urandom_range(1, 12);
		in_valid <= 1'b1;
		command <= e.cmd;
		conn_slot <= e.slot;
		timestamp_ns <= e.ts;
		byte_count <= e.bytes;
		local_addr <= e.laddr;
		remote_addr <= e.raddr;
		local_port <= e.lport;
		remote_port <= e.rport;
		listening <= e.listen;
		proc_id <= e.pid;
		proc_tracked <= e.tracked;
		node_index <= e.nidx;
		do
			@(posedge clk);
		while (!in_ready);
		track_event(e);
		items_sent++;
		burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic event_t make_event(cmd_t c, logic [7:0] s, logic [63:0] ts,
			logic [31:0] la, logic [31:0] ra, logic lis);
		event_t e;
		e.cmd = c;
		e.slot = s;
		e.ts = ts;
		e.bytes = $urandom_range(1, 5000);
		e.laddr = la;
		e.raddr = ra;
		e.lport = 16'($urandom);
		e.rport = 16'($urandom);
		e.listen = lis;
		e.pid = $urandom;
		e.tracked = 1'b1;
		e.nidx = 4'($urandom);
		return e;
	endfunction

	function automatic logic [63:0] tick(int lo, int hi);
		now_ns += 64'($urandom_range(lo, hi));
		return now_ns;
	endfunction

	task automatic test_empty_reads();
		event_t e;
		e = make_event(CMD_READ, 8'd0, 64'd0, 32'd1, 32'd2, 1'b0);
		e.nidx = 4'd0;
		send_event(e);
		e.nidx = 4'hF;
		send_event(e);
	endtask

	task automatic test_ignored_events();
		event_t e;
		e = make_event(CMD_SEND, 8'd7, tick(1, 9), 32'h0A000001, 32'h0A000002, 1'b0);
		e.tracked = 1'b0;
		send_event(e);
		e = make_event(CMD_RECV, 8'd7, tick(1, 9), 32'h0A000003, 32'h0A000003, 1'b0);
		send_event(e);
		e = make_event(CMD_CLOSE, 8'd9, tick(1, 9), 32'h0A000001, 32'h0A000002, 1'b0);
		send_event(e);
	endtask

	task automatic test_client_exchange();
		event_t e;
		e = make_event(CMD_SEND, 8'd0, tick(1000, 90000), 32'hFFFFFFFF, 32'h0, 1'b0);
		e.bytes = 32'hFFFFFFFF;
		e.lport = 16'hFFFF;
		e.rport = 16'h0;
		e.pid = 32'hFFFFFFFF;
		send_event(e);
		e.cmd = CMD_RECV;
		e.ts = tick(1000, 90000);
		send_event(e);
		e.cmd = CMD_SEND;
		e.ts = tick(1000, 90000);
		e.bytes = 32'd0;
		send_event(e);
	endtask

	task automatic test_server_exchange();
		event_t e;
		e = make_event(CMD_RECV, 8'd255, tick(1000, 90000), 32'h0, 32'hFFFFFFFF, 1'b1);
		e.lport = 16'h0;
		e.rport = 16'hFFFF;
		e.pid = 32'h0;
		send_event(e);
		e.cmd = CMD_SEND;
		e.ts = tick(1000, 90000);
		send_event(e);
		e.cmd = CMD_RECV;
		e.ts = tick(1000, 90000);
		send_event(e);
		e.cmd = CMD_CLOSE;
		send_event(e);
	endtask

	task automatic test_negative_window();
		event_t e;
		e = make_event(CMD_SEND, 8'd3, 64'hFFFF_FFFF_FFFF_FFF0, 32'h0B000001,
			32'h0B000002, 1'b0);
		send_event(e);
		e.cmd = CMD_RECV;
		e.ts = 64'd5;
		send_event(e);
		e.cmd = CMD_CLOSE;
		send_event(e);
	endtask

	task automatic test_readback();
		event_t e;
		e = make_event(CMD_READ, 8'd0, 64'd0, 32'd1, 32'd2, 1'b0);
		for (int i = 0; i < 3; i++) begin
			e.nidx = 4'(i);
			send_event(e);
		end
	endtask

	task automatic test_random_traffic();
		event_t e;
		int pick, pool, n;
		logic [7:0] s;
		while (items_sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			pool = (items_sent < RAND_ITEMS / 2) ? 6 : 24;
			if (pick < 70) begin
				s = 8'($urandom_range(0, 9) * 25);
				e = make_event(CMD_SEND, s, now_ns,
					32'hC0A80000 + 32'($urandom_range(0, pool - 1)),
					32'h0A000000 + 32'($urandom_range(0, 3)), 1'($urandom));
				if ($urandom_range(0, 19) == 0)
					now_ns += {$urandom, $urandom} >> $urandom_range(0, 20);
				n = $urandom_range(2, 6);
				for (int k = 0; k < n; k++) begin
					e.cmd = $urandom_range(0, 1) ? CMD_SEND : CMD_RECV;
					e.ts = tick(1, 2000000);
					e.bytes = $urandom;
					send_event(e);
				end
				if ($urandom_range(0, 4) == 0) begin
					e.cmd = CMD_CLOSE;
					e.ts = tick(1, 1000);
					send_event(e);
				end
			end else if (pick < 82) begin
				e = make_event(CMD_READ, 8'd0, 64'd0, 32'd0, 32'd0, 1'b0);
				send_event(e);
			end else begin
				e.cmd = cmd_t'($urandom_range(0, 3));
				e.slot = 8'($urandom);
				e.ts = $urandom_range(0, 3) == 0 ? 64'd0 : {$urandom, $urandom};
				e.bytes = $urandom;
				e.laddr = $urandom;
				e.raddr = $urandom_range(0, 1) ? e.laddr : $urandom;
				e.lport = 16'($urandom);
				e.rport = 16'($urandom);
				e.listen = 1'($urandom);
				e.pid = $urandom;
				e.tracked = 1'($urandom);
				e.nidx = 4'($urandom);
				send_event(e);
			end
		end
		e = make_event(CMD_READ, 8'd0, 64'd0, 32'd0, 32'd0, 1'b0);
		for (int i = 0; i < NODE_ENTRIES; i++) begin
			e.nidx = 4'(i);
			send_event(e);
		end
	endtask

	// receiver stall pattern: phases of always-ready, sparse and random
	int ready_cnt = 0;
	always @(posedge clk) begin
		ready_cnt <= ready_cnt + 1;
		case ((ready_cnt / 96) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= (ready_cnt % 3) == 0;
			2: out_ready <= 1'($urandom);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		beat_t got, exp_b;
		if (out_valid && out_ready) begin
			got = {exchange_done, done_role, response_us, edge_client, edge_server,
				node_dropped, read_word, word_number, last_word};
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %h", got);
			end else begin
				exp_b = expected_beats.pop_front();
				if (got !== exp_b) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp done=%b role=%b rt=%h c=%h s=%h",
							exp_b.done, exp_b.role, exp_b.rt_us, exp_b.eclient,
							exp_b.eserver);
						$display("  exp drop=%b w=%h n=%0d l=%b",
							exp_b.dropped, exp_b.word, exp_b.wnum, exp_b.last);
						$display("  got done=%b role=%b rt=%h c=%h s=%h",
							got.done, got.role, got.rt_us, got.eclient, got.eserver);
						$display("  got drop=%b w=%h n=%0d l=%b",
							got.dropped, got.word, got.wnum, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CONN_SLOTS; i++)
			sl_live[i] = 1'b0;
		for (int i = 0; i < NODE_ENTRIES; i++)
			nd_live[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_reads();
		test_ignored_events();
		test_client_exchange();
		test_server_exchange();
		test_negative_window();
		test_readback();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
